// ===== design/reversible_deque_macros.svh =====
// Assertion macros used by the reversible deque top-level design file.
`ifndef REVERSIBLE_DEQUE_MACROS_SVH
`define REVERSIBLE_DEQUE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RDQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("reversible_deque: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RDQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("reversible_deque: next-cycle check failed");

`endif

// ===== design/rdq_pkg.sv =====
// Types and constants shared by the reversible deque modules.
package rdq_pkg;

  localparam int DEFAULT_DEPTH = 1024;
  localparam int CHAR_W        = 8;
  localparam int MODE_W        = 2;
  localparam int STATUS_W      = 2;
  localparam int IN_TDATA_W    = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH    = 2'd0,
    MODE_REVERSE = 2'd1,
    MODE_POP     = 2'd2
  } rdq_mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } rdq_status_t;

  typedef struct packed {
    logic we;
    logic re;
  } rdq_mem_cmd_t;

  typedef struct packed {
    rdq_status_t status;
    logic        pop_hit;
  } rdq_res_t;

endpackage

// ===== design/reversible_deque.sv =====
// Reversible deque: a bounded byte buffer with push at either logical end, a
// constant-time reverse and a pop from the logical front. Each item gives one
// result item in the cycle after it is accepted, and a new item is taken every
// cycle while the result register is empty or being taken downstream; the
// figure is set by the single storage port, which does one write or one read
// per item and registers the read byte. Storage contents are not cleared at
// reset, but only bytes that were pushed are ever read back.
`include "reversible_deque_macros.svh"

module reversible_deque
  import rdq_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1),
  parameter int OUT_W = ((CHAR_W + STATUS_W + CW + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,   // mode[1:0], side[2], char_in[10:3]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata    // char_out[7:0], status[9:8], fill above
);

  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam int            PAD_W   = OUT_W - CHAR_W - STATUS_W - CW;

  logic              accept;
  rdq_mem_cmd_t      mem_cmd;
  logic [AW-1:0]     mem_addr;
  logic [CHAR_W-1:0] mem_wdata;
  logic [CHAR_W-1:0] rd_data;
  rdq_res_t          res;
  logic [CW-1:0]     occupancy_next;

  rdq_res_t          out_res;
  logic [CW-1:0]     fill;
  logic [CHAR_W-1:0] char_out;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  rdq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .en             (accept),
    .mode           (s_tdata[MODE_W-1:0]),
    .side           (s_tdata[MODE_W]),
    .char_in        (s_tdata[MODE_W+1 +: CHAR_W]),
    .mem_cmd        (mem_cmd),
    .mem_addr       (mem_addr),
    .mem_wdata      (mem_wdata),
    .res            (res),
    .occupancy_next (occupancy_next)
  );

  rdq_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk       (clk),
    .mem_cmd   (mem_cmd),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .rd_data   (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res <= res;
      fill    <= occupancy_next;
    end
  end

  // The popped byte arrives in the storage read register alongside the result.
  assign char_out = out_res.pop_hit ? rd_data : '0;
  assign m_tdata  = {PAD_W'(0), fill, out_res.status, char_out};

  `RDQ_ASSERT_IMPL(a_fill_bound, clk, rst, m_tvalid, fill <= DEPTH_C)
  `RDQ_ASSERT_IMPL(a_full_fill, clk, rst, m_tvalid && out_res.status == STAT_FULL, fill == DEPTH_C)
  `RDQ_ASSERT_IMPL(a_empty_fill, clk, rst, m_tvalid && out_res.status == STAT_EMPTY, fill == '0)
  `RDQ_ASSERT_NEXT(a_pop_ok, clk, rst, accept && res.pop_hit, out_res.status == STAT_OK)

endmodule

// ===== design/rdq_ctrl.sv =====
// Pointer, occupancy and reverse-flag control with storage address generation.
module rdq_ctrl
  import rdq_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [MODE_W-1:0] mode,
  input  logic              side,
  input  logic [CHAR_W-1:0] char_in,
  output rdq_mem_cmd_t      mem_cmd,
  output logic [AW-1:0]     mem_addr,
  output logic [CHAR_W-1:0] mem_wdata,
  output rdq_res_t          res,
  output logic [CW-1:0]     occupancy_next
);

  localparam int            SW       = CW + 1;
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
  localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [CW-1:0] occupancy;
  logic          reversed;
  logic          reversed_next;

  logic [SW-1:0] tail_sum;
  logic [SW-1:0] last_sum;
  logic [AW-1:0] tail_idx;
  logic [AW-1:0] last_idx;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] head_inc;
  logic          full;
  logic          empty;
  logic          phys_front;

  assign full       = (occupancy == DEPTH_C);
  assign empty      = (occupancy == '0);
  assign phys_front = (side == 1'b0) ^ reversed;

  // Both sums stay below twice the depth, so one conditional subtract wraps them.
  assign tail_sum = SW'(head) + SW'(occupancy);
  assign last_sum = tail_sum - SW'(1);
  assign tail_idx = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
  assign last_idx = (last_sum >= DEPTH_S) ? AW'(last_sum - DEPTH_S) : AW'(last_sum);
  assign head_dec = (head == '0) ? LAST_IDX : head - AW'(1);
  assign head_inc = (head == LAST_IDX) ? '0 : head + AW'(1);

  assign mem_wdata = char_in;

  always_comb begin
    head_next      = head;
    occupancy_next = occupancy;
    reversed_next  = reversed;
    mem_cmd        = '{we: 1'b0, re: 1'b0};
    mem_addr       = head;
    res            = '{status: STAT_OK, pop_hit: 1'b0};
    unique case (mode)
      MODE_PUSH: begin
        if (full) begin
          res.status = STAT_FULL;
        end else begin
          mem_cmd.we     = 1'b1;
          occupancy_next = occupancy + CW'(1);
          if (phys_front) begin
            head_next = head_dec;
            mem_addr  = head_dec;
          end else begin
            mem_addr = tail_idx;
          end
        end
      end
      MODE_REVERSE: begin
        reversed_next = ~reversed;
      end
      MODE_POP: begin
        if (empty) begin
          res.status = STAT_EMPTY;
        end else begin
          mem_cmd.re     = 1'b1;
          res.pop_hit    = 1'b1;
          occupancy_next = occupancy - CW'(1);
          if (reversed) begin
            mem_addr = last_idx;
          end else begin
            head_next = head_inc;
          end
        end
      end
      default: begin
        // The unused code leaves everything as it is.
      end
    endcase
    if (!en) begin
      mem_cmd = '{we: 1'b0, re: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      occupancy <= '0;
      reversed  <= 1'b0;
    end else if (en) begin
      head      <= head_next;
      occupancy <= occupancy_next;
      reversed  <= reversed_next;
    end
  end

endmodule

// ===== design/rdq_mem.sv =====
// Single-port byte storage with registered read data.
module rdq_mem
  import rdq_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  rdq_mem_cmd_t      mem_cmd,
  input  logic [AW-1:0]     mem_addr,
  input  logic [CHAR_W-1:0] mem_wdata,
  output logic [CHAR_W-1:0] rd_data
);

  logic [CHAR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (mem_cmd.we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_cmd.re) begin
      rd_data <= mem[mem_addr];
    end
  end

endmodule

// ===== test/reversible_deque_tb.sv =====
// Self-checking testbench for the reversible deque: random push, reverse and pop traffic.
module reversible_deque_tb;
  import rdq_pkg::*;

  localparam int DEPTH  = DEFAULT_DEPTH;
  localparam int AW     = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int OUT_W  = ((CHAR_W + STATUS_W + FILL_W + 7) / 8) * 8;

  // The block does not decode this mode and must treat it as a no-op.
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam int HOLD_OFF_CYCLES = 400;
  localparam int RANDOM_TARGET   = 1400;

  typedef struct {
    logic [CHAR_W-1:0] char_out;
    rdq_status_t       status;
    logic [FILL_W-1:0] fill;
  } deque_result_t;

  // Shadow copy of the deque plus the results still owed by the block.
  class deque_shadow;
    logic [CHAR_W-1:0] slots [DEPTH];
    logic [AW-1:0]     head;
    logic [FILL_W-1:0] fill;
    logic              reversed;
    deque_result_t     owed[$];
    int                ops;
    int                checked;
    int                errors;
    int                full_drops;
    int                empty_pops;

    function new();
      head       = '0;
      fill       = '0;
      reversed   = 1'b0;
      ops        = 0;
      checked    = 0;
      errors     = 0;
      full_drops = 0;
      empty_pops = 0;
    endfunction

    function void note_op(logic [MODE_W-1:0] mode, logic side, logic [CHAR_W-1:0] ch);
      deque_result_t r;
      logic [AW-1:0] idx;
      r.char_out = '0;
      r.status   = STAT_OK;
      ops++;
      if (mode == MODE_PUSH) begin
        if (fill >= DEPTH) begin
          r.status = STAT_FULL;
          full_drops++;
        end else begin
          // While reversed, the logical front lives at the physical back.
          if ((side == 1'b0) ^ reversed) begin
            head        = head - 1'b1;
            slots[head] = ch;
          end else begin
            idx        = head + fill[AW-1:0];
            slots[idx] = ch;
          end
          fill = fill + 1'b1;
        end
      end else if (mode == MODE_REVERSE) begin
        reversed = ~reversed;
      end else if (mode == MODE_POP) begin
        if (fill == 0) begin
          r.status = STAT_EMPTY;
          empty_pops++;
        end else begin
          if (reversed) begin
            idx        = head + fill[AW-1:0] - 1'b1;
            r.char_out = slots[idx];
          end else begin
            r.char_out = slots[head];
            head       = head + 1'b1;
          end
          fill = fill - 1'b1;
        end
      end
      r.fill = fill;
      owed = {owed, r};
    endfunction

    function void check_result(logic [OUT_W-1:0] word);
      deque_result_t     want;
      logic [CHAR_W-1:0]   got_char;
      logic [STATUS_W-1:0] got_status;
      logic [FILL_W-1:0]   got_fill;
      got_char   = word[CHAR_W-1:0];
      got_status = word[CHAR_W +: STATUS_W];
      got_fill   = word[CHAR_W + STATUS_W +: FILL_W];
      if (owed.size() == 0) begin
        $error("result item %0h arrived with no operation outstanding", word);
        errors++;
        return;
      end
      want = owed.pop_front();
      checked++;
      if (got_char !== want.char_out) begin
        $error("char_out mismatch: expected %0h, got %0h", want.char_out, got_char);
        errors++;
      end
      if (got_status !== want.status) begin
        $error("status mismatch: expected %0d, got %0d", want.status, got_status);
        errors++;
      end
      if (got_fill !== want.fill) begin
        $error("fill mismatch: expected %0d, got %0d", want.fill, got_fill);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_TDATA_W-1:0] s_tdata;   // mode[1:0], side[2], char_in[10:3]
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_W-1:0]      m_tdata;   // char_out[7:0], status[9:8], fill[20:10]

  deque_shadow shadow;
  bit          sender_steady;
  bit          hold_off_req;
  bit          hold_off_done;
  int          random_ops;

  reversible_deque dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_op(logic [MODE_W-1:0] mode, logic side, logic [CHAR_W-1:0] ch);
    int gap;
    gap = pick_gap(sender_steady);
    @(negedge clk);
    repeat (gap) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W - CHAR_W - 1 - MODE_W){1'b0}}, ch, side, mode};
    do @(posedge clk); while (!s_tready);
    shadow.note_op(mode, side, ch);
  endtask

  // Weights are percentages; whatever is left goes to the undecoded mode.
  task automatic send_random(int w_push, int w_rev, int w_pop);
    int r;
    logic [MODE_W-1:0] mode;
    r = $urandom_range(0, 99);
    if (r < w_push) mode = MODE_PUSH;
    else if (r < w_push + w_rev) mode = MODE_REVERSE;
    else if (r < w_push + w_rev + w_pop) mode = MODE_POP;
    else mode = MODE_SPARE;
    send_op(mode, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    random_ops++;
  endtask

  // Receiver: random stalls, occasional always-ready bursts, and one long hold-off on request.
  initial begin
    int stall_left;
    int burst_left;
    stall_left    = 0;
    burst_left    = 0;
    hold_off_done = 1'b0;
    m_tready      = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else if (burst_left > 0) begin
        m_tready <= 1'b1;
        burst_left--;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        stall_left = pick_gap(1'b0);
        if ($urandom_range(0, 99) < 2) burst_left = $urandom_range(40, 120);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) shadow.check_result(m_tdata);
  end

  initial begin
    shadow        = new();
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    rst           = 1'b1;
    sender_steady = 1'b0;
    hold_off_req  = 1'b0;
    random_ops    = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty pops, the undecoded mode, both push sides with and
    // without reversal, and the side bit set on operations that ignore it.
    send_op(MODE_POP,     1'b0, 8'h00);
    send_op(MODE_POP,     1'b1, 8'hFF);
    send_op(MODE_SPARE,   1'b1, 8'hFF);
    send_op(MODE_PUSH,    1'b1, 8'h00);
    send_op(MODE_PUSH,    1'b1, 8'hFF);
    send_op(MODE_PUSH,    1'b0, 8'hA5);
    send_op(MODE_PUSH,    1'b0, 8'h5A);
    send_op(MODE_REVERSE, 1'b1, 8'hFF);
    send_op(MODE_PUSH,    1'b0, 8'h01);
    send_op(MODE_PUSH,    1'b1, 8'h80);
    send_op(MODE_POP,     1'b1, 8'hFF);
    send_op(MODE_SPARE,   1'b0, 8'h00);
    send_op(MODE_POP,     1'b0, 8'h00);
    send_op(MODE_REVERSE, 1'b0, 8'h00);
    send_op(MODE_POP,     1'b0, 8'h00);
    send_op(MODE_PUSH,    1'b0, 8'h7F);
    send_op(MODE_POP,     1'b1, 8'h00);
    send_op(MODE_POP,     1'b0, 8'h00);
    send_op(MODE_POP,     1'b0, 8'h00);
    send_op(MODE_POP,     1'b0, 8'h00);
    send_op(MODE_POP,     1'b1, 8'hFF);

    // Balanced traffic that keeps hitting the empty buffer.
    repeat (150) begin
      sender_steady = (random_ops >= 60 && random_ops < 100);
      send_random(40, 15, 40);
    end

    // Fill to the brim; halfway up the receiver stops for a long while.
    while (shadow.fill < DEPTH) begin
      if (shadow.fill >= DEPTH / 2) hold_off_req = 1'b1;
      sender_steady = (shadow.fill >= 700 && shadow.fill < 800);
      send_random(88, 7, 3);
    end
    sender_steady = 1'b0;
    repeat (8) send_random(80, 20, 0);

    while (shadow.fill > 0 && random_ops < RANDOM_TARGET) send_random(8, 8, 80);
    repeat (40) send_random(40, 15, 40);

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (shadow.owed.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Checked %0d result items from %0d operations (%0d random).",
             shadow.checked, shadow.ops, random_ops);
    $display("Pushes dropped at full: %0d, pops on empty: %0d.",
             shadow.full_drops, shadow.empty_pops);
    if (shadow.errors == 0 && shadow.owed.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
